FILE: hdl/sobm_pkg.sv
// ----------------------------------------------------------------------------
// sobm_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sobm_pkg;

  localparam int PIX_BITS    = 8;
  localparam int CFG_W_BITS  = 11;
  localparam int CFG_H_BITS  = 13;
  localparam int ROW_BITS    = 12;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MIN_SIZE    = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [PIX_BITS-1:0] MAG_MAX = 8'd255;

  // register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic [CFG_W_BITS-1:0] image_width;
    logic [CFG_H_BITS-1:0] image_height;
  } cfg_t;

  // control of the beat that sits between memory read and output register
  typedef struct packed {
    logic                valid;
    logic                is_pixel;
    logic                emit;
    logic                interior;
    logic                frame_end;
    logic [PIX_BITS-1:0] pixel;
  } s1_t;

endpackage

FILE: hdl/sobm_if.sv
// ----------------------------------------------------------------------------
// sobm_if
// Stream channels: pixel input and edge magnitude result.
// ----------------------------------------------------------------------------
interface sobm_pix_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] pixel;

  modport source (output valid, output kind, output pixel, input ready);
  modport sink   (input valid, input kind, input pixel, output ready);
endinterface

interface sobm_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_magnitude;
  logic       frame_end;

  modport source (output valid, output edge_magnitude, output frame_end, input ready);
  modport sink   (input valid, input edge_magnitude, input frame_end, output ready);
endinterface

FILE: hdl/sobm_cfg.sv
// ----------------------------------------------------------------------------
// sobm_cfg
// APB register file holding the frame width and height.
// ----------------------------------------------------------------------------
module sobm_cfg
  import sobm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [CFG_W_BITS-1:0] width_q, width_d;
  logic [CFG_H_BITS-1:0] height_q, height_d;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  width_d  = pwdata[CFG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: height_d = pwdata[CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W_BITS'(640);
      height_q <= CFG_H_BITS'(480);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign cfg_o.image_width  = width_q;
  assign cfg_o.image_height = height_q;

endmodule

FILE: hdl/sobm_line_mem.sv
// ----------------------------------------------------------------------------
// sobm_line_mem
// Line store: one word per column holding the two previous lines.
// ----------------------------------------------------------------------------
module sobm_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/sobm_window.sv
// ----------------------------------------------------------------------------
// sobm_window
// 3x3 window, Sobel L1 magnitude and the output register.
// ----------------------------------------------------------------------------
module sobm_window
  import sobm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  s1_t                 s1_i,
  input  logic [PIX_BITS-1:0] top_i,
  input  logic [PIX_BITS-1:0] mid_i,
  output logic                adv_o,
  sobm_res_if.source          res_o
);

  logic [PIX_BITS-1:0] win_q [3][3];
  logic [PIX_BITS-1:0] win_d [3][3];
  logic                out_valid_q, out_valid_d;
  logic [PIX_BITS-1:0] out_mag_q, out_mag_d;
  logic                out_fend_q, out_fend_d;
  logic [PIX_BITS-1:0] mag;

  function automatic logic [PIX_BITS-1:0] sobel_l1(input logic [PIX_BITS-1:0] w [3][3]);
    logic [9:0]         sx_p, sx_n, sy_p, sy_n;
    logic signed [10:0] gx, gy;
    logic [10:0]        ax, ay;
    logic [10:0]        sum;
    sx_p = {2'b0, w[0][2]} + {1'b0, w[1][2], 1'b0} + {2'b0, w[2][2]};
    sx_n = {2'b0, w[0][0]} + {1'b0, w[1][0], 1'b0} + {2'b0, w[2][0]};
    sy_p = {2'b0, w[2][0]} + {1'b0, w[2][1], 1'b0} + {2'b0, w[2][2]};
    sy_n = {2'b0, w[0][0]} + {1'b0, w[0][1], 1'b0} + {2'b0, w[0][2]};
    gx   = $signed({1'b0, sx_p}) - $signed({1'b0, sx_n});
    gy   = $signed({1'b0, sy_p}) - $signed({1'b0, sy_n});
    ax   = gx[10] ? 11'(-gx) : 11'(gx);
    ay   = gy[10] ? 11'(-gy) : 11'(gy);
    sum  = ax + ay;
    return (sum > 11'(MAG_MAX)) ? MAG_MAX : sum[PIX_BITS-1:0];
  endfunction

  // stall the whole pipe only while a finished beat waits at the output
  assign adv_o = !out_valid_q || res_o.ready;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = top_i;
    win_d[1][2] = mid_i;
    win_d[2][2] = s1_i.pixel;
  end

  assign mag = sobel_l1(win_d);

  always_comb begin
    out_valid_d = out_valid_q;
    out_mag_d   = out_mag_q;
    out_fend_d  = out_fend_q;
    if (adv_o) begin
      out_valid_d = s1_i.valid && s1_i.emit;
      out_mag_d   = (s1_i.is_pixel && s1_i.interior) ? mag : '0;
      out_fend_d  = s1_i.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (adv_o && s1_i.valid && s1_i.is_pixel) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_mag_q  <= out_mag_d;
    out_fend_q <= out_fend_d;
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.edge_magnitude = out_mag_q;
  assign res_o.frame_end      = out_fend_q;

endmodule

FILE: hdl/sobel_edge_magnitude.sv
// Path: an accepted pixel passes the s1 register, then the output register, to its result beat.
// Throughput: one item per cycle unless res_o stalls, with one line store read and write.
// Results trail pixels by clamped width + 1 items; drain beats push out the frame tail.
// Reset: width 640, height 480, window and position counters cleared; line store not cleared.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel L1 edge magnitude over a raster pixel stream.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude
  import sobm_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sobm_pix_if.sink              pix_i,
  sobm_res_if.source            res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(MAX_WIDTH + 2);
  localparam int CW = (WW > CFG_W_BITS) ? WW : CFG_W_BITS;

  cfg_t                  cfg;
  logic [WW-1:0]         eff_w;
  logic [CFG_H_BITS-1:0] eff_h;
  logic [CW-1:0]         w_ext;

  logic [XW-1:0]         col_q, col_d;
  logic [ROW_BITS-1:0]   row_q, row_d;
  logic [PW-1:0]         pend_q, pend_d;
  s1_t                   s1_q, s1_d;

  logic                  adv;
  logic                  accept;
  logic                  is_pixel;
  logic                  drain_ok;
  logic [WW-1:0]         col_inc;
  logic [CFG_H_BITS-1:0] row_inc;
  logic [PW-1:0]         full;
  logic                  pix_emit;
  logic                  interior;
  logic [2*PIX_BITS-1:0] rd_word;
  logic [XW-1:0]         wr_col_q;

  sobm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // clamp the frame size to the supported range
  assign w_ext = CW'(cfg.image_width);

  always_comb begin
    if (w_ext < CW'(MIN_SIZE)) begin
      eff_w = WW'(MIN_SIZE);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(w_ext);
    end
    if (cfg.image_height < CFG_H_BITS'(MIN_SIZE)) begin
      eff_h = CFG_H_BITS'(MIN_SIZE);
    end else if (cfg.image_height > CFG_H_BITS'(MAX_HEIGHT)) begin
      eff_h = CFG_H_BITS'(MAX_HEIGHT);
    end else begin
      eff_h = cfg.image_height;
    end
  end

  assign pix_i.ready = adv;
  assign accept      = pix_i.valid && adv;
  assign is_pixel    = (pix_i.kind == KIND_PIXEL);

  assign col_inc  = WW'(col_q) + WW'(1);
  assign row_inc  = CFG_H_BITS'(row_q) + CFG_H_BITS'(1);
  assign full     = PW'(eff_w) + PW'(1);
  assign pix_emit = (pend_q >= full);
  assign drain_ok = (col_q == '0) && (row_q == '0) && (pend_q != '0);
  assign interior = (col_q >= XW'(2)) && (WW'(col_q) < eff_w) &&
                    (row_q >= ROW_BITS'(2)) && (CFG_H_BITS'(row_q) < eff_h);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    s1_d   = s1_q;
    if (adv) begin
      s1_d.valid     = accept;
      s1_d.is_pixel  = is_pixel;
      s1_d.pixel     = pix_i.pixel;
      s1_d.interior  = interior;
      s1_d.emit      = is_pixel ? pix_emit : drain_ok;
      s1_d.frame_end = is_pixel ? ((col_q == '0) && (row_q == ROW_BITS'(1)))
                                : (pend_q == PW'(1));
    end
    if (accept && is_pixel) begin
      pend_d = pix_emit ? full : pend_q + PW'(1);
      if (col_inc >= eff_w) begin
        col_d = '0;
        row_d = (row_inc >= eff_h) ? '0 : ROW_BITS'(row_inc);
      end else begin
        col_d = XW'(col_inc);
      end
    end else if (accept && drain_ok) begin
      pend_d = pend_q - PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q          <= '0;
      row_q          <= '0;
      pend_q         <= '0;
      s1_q.valid     <= 1'b0;
      s1_q.is_pixel  <= 1'b0;
      s1_q.emit      <= 1'b0;
      s1_q.interior  <= 1'b0;
      s1_q.frame_end <= 1'b0;
      s1_q.pixel     <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
      s1_q   <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wr_col_q <= col_q;
    end
  end

  // The write of a column lands before the next pixel after it is read, and the
  // same column comes back only three or more pixels later: no forwarding needed.
  sobm_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PIX_BITS),
    .ADDR_W (XW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept && is_pixel),
    .rd_addr_i (col_q),
    .rd_data_o (rd_word),
    .wr_en_i   (adv && s1_q.valid && s1_q.is_pixel),
    .wr_addr_i (wr_col_q),
    .wr_data_i ({rd_word[PIX_BITS-1:0], s1_q.pixel})
  );

  sobm_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s1_i   (s1_q),
    .top_i  (rd_word[2*PIX_BITS-1:PIX_BITS]),
    .mid_i  (rd_word[PIX_BITS-1:0]),
    .adv_o  (adv),
    .res_o  (res_o)
  );

endmodule
